[src/pfd_pkg.sv]
// Shared constants, types and the slot-to-role map of the PPM frame decoder.
package pfd_pkg;

    localparam int          CNT_W          = 16;
    localparam logic [15:0] CNT_MAX        = 16'hFFFF;
    localparam logic [15:0] SYNC_THR_RESET = 16'd7000;
    localparam int          NUM_SLOTS_DEF  = 8;

    // Stick roles carried on the result
    localparam logic [2:0] ROLE_ROLL     = 3'd0;
    localparam logic [2:0] ROLE_PITCH    = 3'd1;
    localparam logic [2:0] ROLE_THROTTLE = 3'd2;
    localparam logic [2:0] ROLE_YAW      = 3'd3;
    localparam logic [2:0] ROLE_AUX1     = 3'd4;
    localparam logic [2:0] ROLE_AUX2     = 3'd5;
    localparam logic [2:0] ROLE_AUX3     = 3'd6;
    localparam logic [2:0] ROLE_AUX4     = 3'd7;

    // Falling-edge event from the pulse measurement
    typedef struct packed {
        logic             fall;
        logic [CNT_W-1:0] width;
    } t_meas_evt;

    function automatic logic [2:0] pfd_role(input logic [2:0] slot);
        logic [2:0] role;
        unique case (slot)
            3'd0:    role = ROLE_PITCH;
            3'd1:    role = ROLE_YAW;
            3'd2:    role = ROLE_AUX2;
            3'd3:    role = ROLE_AUX4;
            3'd4:    role = ROLE_ROLL;
            3'd5:    role = ROLE_THROTTLE;
            3'd6:    role = ROLE_AUX1;
            default: role = ROLE_AUX3;
        endcase
        return role;
    endfunction

endpackage

[src/pfd_pulse_meas.sv]
// Edge detection and saturating high-time counter for the PPM pin.
module pfd_pulse_meas (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_level,
    output pfd_pkg::t_meas_evt o_evt
);
    import pfd_pkg::*;

    logic             r_prev_level;
    logic             r_high_seen;
    logic [CNT_W-1:0] r_count;
    logic             n_prev_level;
    logic             n_high_seen;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_prev_level = i_level;
        n_high_seen  = r_high_seen;
        n_count      = r_count;
        o_evt.fall   = 1'b0;
        // pulse of one tick measures zero
        if (r_count == '0) begin
            o_evt.width = '0;
        end else if (r_count != CNT_MAX) begin
            o_evt.width = r_count + 1'b1;
        end else begin
            o_evt.width = CNT_MAX;
        end
        priority if (i_level && !r_prev_level) begin
            n_count     = '0;
            n_high_seen = 1'b1;
        end else if (i_level) begin
            if (r_count != CNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end else if (r_prev_level && r_high_seen) begin
            o_evt.fall  = 1'b1;
            n_high_seen = 1'b0;
        end else begin
            // low with no pending high: hold
            n_high_seen = r_high_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_high_seen  <= 1'b0;
            r_count      <= '0;
        end else if (i_en) begin
            r_prev_level <= n_prev_level;
            r_high_seen  <= n_high_seen;
            r_count      <= n_count;
        end
    end

endmodule

[src/ppm_frame_decoder_top.sv]
// Result: a falling edge on the accepted tick is registered and shown in the next cycle.
// Throughput: one tick per cycle; the next tick is taken while a result waits,
// as long as the single result register is free or drains in the same cycle.
// Reset: synchronous active low; clears edge, counter and frame state, sets
// sync_threshold to 7000 and drops o_out_valid.
// Top level of the PPM frame decoder: frame slot tracking and result register.
module ppm_frame_decoder_top #(
    parameter int NUM_SLOTS = pfd_pkg::NUM_SLOTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_pin_level,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [pfd_pkg::CNT_W-1:0] i_cfg_sync_threshold,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [2:0]              o_slot_index,
    output logic [2:0]              o_stick_role,
    output logic [pfd_pkg::CNT_W-1:0] o_pulse_width,
    output logic                    o_frame_last
);
    import pfd_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic              w_accept;
    t_meas_evt         w_evt;
    logic              w_last;
    logic              w_emit;

    logic [CNT_W-1:0]  r_sync_thr;
    logic              r_frame_valid;
    logic [SLOT_W-1:0] r_slot;
    logic              n_frame_valid;
    logic [SLOT_W-1:0] n_slot;

    logic              r_out_valid;
    logic [2:0]        r_slot_index;
    logic [2:0]        r_stick_role;
    logic [CNT_W-1:0]  r_pulse_width;
    logic              r_frame_last;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    pfd_pulse_meas u_meas (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_accept),
        .i_level (i_pin_level),
        .o_evt   (w_evt)
    );

    assign w_last = (r_slot == SLOT_W'(NUM_SLOTS - 1));
    assign w_emit = w_accept && w_evt.fall && r_frame_valid;

    always_comb begin
        n_frame_valid = r_frame_valid;
        n_slot        = r_slot;
        if (w_evt.fall) begin
            if (r_frame_valid) begin
                if (w_last) begin
                    n_frame_valid = 1'b0;
                    n_slot        = '0;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            // sync pulse restarts the frame after the slot decision
            if (w_evt.width > r_sync_thr) begin
                n_frame_valid = 1'b1;
                n_slot        = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_thr    <= SYNC_THR_RESET;
            r_frame_valid <= 1'b0;
            r_slot        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sync_thr <= i_cfg_sync_threshold;
            end
            if (w_accept) begin
                r_frame_valid <= n_frame_valid;
                r_slot        <= n_slot;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_slot_index  <= 3'(r_slot);
            r_stick_role  <= pfd_role(3'(r_slot));
            r_pulse_width <= w_evt.width;
            r_frame_last  <= w_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot_index  = r_slot_index;
    assign o_stick_role  = r_stick_role;
    assign o_pulse_width = r_pulse_width;
    assign o_frame_last  = r_frame_last;

endmodule

[src/pfd_checker.sv]
// Port-level assertions for the PPM frame decoder, bound to the top level.
module pfd_checker #(
    parameter int NUM_SLOTS = pfd_pkg::NUM_SLOTS_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      i_pin_level,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [2:0]                o_slot_index,
    input logic [2:0]                o_stick_role,
    input logic [pfd_pkg::CNT_W-1:0] o_pulse_width,
    input logic                      o_frame_last
);
    import pfd_pkg::*;

    localparam logic [2:0] LAST_IDX = 3'(NUM_SLOTS - 1);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_slot_index)
            && $stable(o_pulse_width) && $stable(o_frame_last))
        else $error("stalled result changed");

    a_role_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_stick_role == pfd_role(o_slot_index))
        else $error("stick role does not match slot");

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_frame_last == (o_slot_index == LAST_IDX)
            || NUM_SLOTS > 8)
        else $error("frame_last on wrong slot");

    // a new result only follows an accepted low tick
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && !i_pin_level))
        else $error("result without falling edge");

endmodule

bind ppm_frame_decoder_top pfd_checker #(.NUM_SLOTS(NUM_SLOTS)) u_pfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_pin_level   (i_pin_level),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_slot_index  (o_slot_index),
    .o_stick_role  (o_stick_role),
    .o_pulse_width (o_pulse_width),
    .o_frame_last  (o_frame_last)
);
